// File: design/sts_pkg.sv
// Shared types, token codes and scan modes for the script token scanner.
package sts_pkg;

	localparam int TOKEN_BITS = 63;

	localparam logic [5:0] K_DOT        = 6'd6;
	localparam logic [5:0] K_PLUS       = 6'd10;
	localparam logic [5:0] K_PLUSPLUS   = 6'd11;
	localparam logic [5:0] K_MINUS      = 6'd12;
	localparam logic [5:0] K_MINUSMINUS = 6'd13;
	localparam logic [5:0] K_SLASH      = 6'd14;
	localparam logic [5:0] K_BANG       = 6'd17;
	localparam logic [5:0] K_BANG_EQ    = 6'd18;
	localparam logic [5:0] K_ASSIGN     = 6'd19;
	localparam logic [5:0] K_EQ_EQ      = 6'd20;
	localparam logic [5:0] K_LESS       = 6'd21;
	localparam logic [5:0] K_LESS_EQ    = 6'd22;
	localparam logic [5:0] K_GREATER    = 6'd23;
	localparam logic [5:0] K_GREATER_EQ = 6'd24;
	localparam logic [5:0] K_IDENT      = 6'd25;
	localparam logic [5:0] K_STRING     = 6'd26;
	localparam logic [5:0] K_NUMBER     = 6'd27;
	localparam logic [5:0] K_KW_BASE    = 6'd28;
	localparam logic [5:0] K_ERR_STRING = 6'd60;
	localparam logic [5:0] K_ERR_CHAR   = 6'd61;
	localparam logic [5:0] K_EOF        = 6'd62;
	localparam logic [5:0] K_NONE       = 6'd63;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_OP, M_LINECMT, M_BLOCK, M_STAR
	} scan_mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [23:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic        last;
	} token_t;

	// Keywords packed first byte lowest, with their lengths.
	function automatic logic [63:0] kw_word(input logic [4:0] k);
		case (k)
			5'd0:  kw_word = 64'h646e61;
			5'd1:  kw_word = 64'h6b61657262;
			5'd2:  kw_word = 64'h65736163;
			5'd3:  kw_word = 64'h7373616c63;
			5'd4:  kw_word = 64'h65756e69746e6f63;
			5'd5:  kw_word = 64'h746c7561666564;
			5'd6:  kw_word = 64'h656e69666564;
			5'd7:  kw_word = 64'h6f64;
			5'd8:  kw_word = 64'h65736c65;
			5'd9:  kw_word = 64'h6669646e65;
			5'd10: kw_word = 64'h65736c6166;
			5'd11: kw_word = 64'h726f66;
			5'd12: kw_word = 64'h6669;
			5'd13: kw_word = 64'h746f6e5f6669;
			5'd14: kw_word = 64'h6665646669;
			5'd15: kw_word = 64'h6665646e6669;
			5'd16: kw_word = 64'h6c706d69;
			5'd17: kw_word = 64'h6564756c636e69;
			5'd18: kw_word = 64'h706d756a;
			5'd19: kw_word = 64'h74656c;
			5'd20: kw_word = 64'h6c6562616c;
			5'd21: kw_word = 64'h726f;
			5'd22: kw_word = 64'h73736170;
			5'd23: kw_word = 64'h746e697270;
			5'd24: kw_word = 64'h6e7275746572;
			5'd25: kw_word = 64'h686374697773;
			5'd26: kw_word = 64'h65757274;
			5'd27: kw_word = 64'h726176;
			5'd28: kw_word = 64'h64696f76;
			5'd29: kw_word = 64'h726f74636576;
			5'd30: kw_word = 64'h70616d68736168;
			default: kw_word = 64'h656c696877;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input logic [4:0] k);
		case (k)
			5'd0, 5'd11, 5'd19, 5'd27: kw_len = 4'd3;
			5'd7, 5'd12, 5'd21: kw_len = 4'd2;
			5'd2, 5'd8, 5'd16, 5'd18, 5'd22, 5'd26, 5'd28: kw_len = 4'd4;
			5'd1, 5'd3, 5'd9, 5'd10, 5'd14, 5'd20, 5'd23, 5'd31: kw_len = 4'd5;
			5'd6, 5'd13, 5'd15, 5'd24, 5'd25, 5'd29: kw_len = 4'd6;
			5'd5, 5'd17, 5'd30: kw_len = 4'd7;
			default: kw_len = 4'd8;
		endcase
	endfunction

endpackage

// File: design/sts_if.sv
// Valid/ready channel interface carrying one payload word.
interface sts_if #(parameter int W = 9) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/sts_front.sv
// Scanner front end: one byte per cycle when stepped, giving up to four tokens.
module sts_front #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            source_byte,
	input  logic                  end_of_source,
	output sts_pkg::token_t [3:0] toks,
	output logic [2:0]            tok_count
);
	import sts_pkg::*;

	scan_mode_t            mode_q;
	logic [OFFSET_BITS-1:0] off_q, origin_q;
	logic [15:0]           line_q, run_q;
	logic [63:0]           prefix_q;
	logic [7:0]            pend_q;

	scan_mode_t            m;
	logic [OFFSET_BITS-1:0] off_n, origin_n;
	logic [15:0]           line_n, run_n;
	logic [63:0]           prefix_n;
	logic [7:0]            pend_n;
	logic [5:0]            wk;

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
	endfunction
	function automatic logic is_num(input logic [7:0] c);
		is_num = c >= 8'h30 && c <= 8'h39;
	endfunction
	function automatic logic [15:0] sat(input logic [15:0] v);
		sat = (v == 16'hffff) ? v : v + 16'd1;
	endfunction
	function automatic logic [5:0] op1(input logic [7:0] p);
		case (p)
			8'h2b: op1 = K_PLUS;
			8'h2d: op1 = K_MINUS;
			8'h21: op1 = K_BANG;
			8'h3d: op1 = K_ASSIGN;
			8'h3c: op1 = K_LESS;
			8'h3e: op1 = K_GREATER;
			default: op1 = K_SLASH;
		endcase
	endfunction
	// Exact keyword match of a whole identifier, given its prefix and length.
	function automatic logic [5:0] kw_kind(input logic [63:0] p, input logic [15:0] r);
		kw_kind = K_IDENT;
		if (r <= 16'd8) begin
			for (int k = 0; k < 32; k++) begin
				if (p == kw_word(5'(k)) && r[3:0] == kw_len(5'(k)))
					kw_kind = K_KW_BASE + 6'(k);
			end
		end
	endfunction

	// Keyword match on the captured prefix.
	always_comb begin
		wk = kw_kind(prefix_q, run_q);
	end

	always_comb begin
		logic [2:0] n;
		logic       again;
		logic [5:0] k1;
		logic [7:0] c;
		n = 3'd0;
		toks = '0;
		m = mode_q; off_n = off_q; origin_n = origin_q; line_n = line_q;
		run_n = run_q; prefix_n = prefix_q; pend_n = pend_q;
		c = source_byte;
		again = 1'b0;
		k1 = K_NONE;
		for (int i = 0; i < 4; i++) toks[i].line = line_q;
		if (c != 8'h00) begin
			unique case (mode_q)
				M_IDENT: begin
					if (is_letter(c) || is_num(c)) begin
						if (run_q < 16'd8) prefix_n = prefix_q | (64'(c) << {run_q[2:0], 3'b000});
						run_n = sat(run_q);
					end else begin
						toks[n] = '{wk, 24'(origin_q), run_q, line_q, 1'b0}; n = n + 3'd1;
						again = 1'b1;
					end
				end
				M_INT: begin
					if (is_num(c)) run_n = sat(run_q);
					else if (c == 8'h2e) m = M_DOT;
					else begin
						toks[n] = '{K_NUMBER, 24'(origin_q), run_q, line_q, 1'b0}; n = n + 3'd1;
						again = 1'b1;
					end
				end
				M_DOT: begin
					if (is_num(c)) begin run_n = sat(sat(run_q)); m = M_FRAC; end
					else begin
						toks[n] = '{K_NUMBER, 24'(origin_q), run_q, line_q, 1'b0}; n = n + 3'd1;
						toks[n] = '{K_DOT, 24'(off_q - OFFSET_BITS'(1)), 16'd1, line_q, 1'b0};
						n = n + 3'd1;
						again = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_num(c)) run_n = sat(run_q);
					else begin
						toks[n] = '{K_NUMBER, 24'(origin_q), run_q, line_q, 1'b0}; n = n + 3'd1;
						again = 1'b1;
					end
				end
				M_STR: begin
					run_n = sat(run_q);
					if (c == 8'h22) begin
						toks[n] = '{K_STRING, 24'(origin_q), run_n, line_q, 1'b0}; n = n + 3'd1;
						m = M_IDLE;
					end else if (c == 8'h0a) line_n = sat(line_q);
				end
				M_OP: begin
					if (pend_q == 8'h2f && (c == 8'h2f || c == 8'h2a)) begin
						m = (c == 8'h2f) ? M_LINECMT : M_BLOCK; pend_n = 8'h00;
					end else if ((pend_q == 8'h2b && c == 8'h2b) ||
					             (pend_q == 8'h2d && c == 8'h2d)) begin
						toks[n] = '{(pend_q == 8'h2b) ? K_PLUSPLUS : K_MINUSMINUS,
						            24'(origin_q), 16'd2, line_q, 1'b0};
						n = n + 3'd1; pend_n = 8'h00; m = M_IDLE;
					end else if (pend_q != 8'h2b && pend_q != 8'h2d && pend_q != 8'h2f &&
					             c == 8'h3d) begin
						toks[n] = '{(pend_q == 8'h21) ? K_BANG_EQ : (pend_q == 8'h3d) ? K_EQ_EQ :
						            (pend_q == 8'h3c) ? K_LESS_EQ : K_GREATER_EQ,
						            24'(origin_q), 16'd2, line_q, 1'b0};
						n = n + 3'd1; pend_n = 8'h00; m = M_IDLE;
					end else begin
						toks[n] = '{op1(pend_q), 24'(origin_q), 16'd1, line_q, 1'b0};
						n = n + 3'd1; pend_n = 8'h00; again = 1'b1;
					end
				end
				M_LINECMT: if (c == 8'h0a) again = 1'b1;
				M_BLOCK: begin
					if (c == 8'h2a) m = M_STAR;
					else if (c == 8'h0a) line_n = sat(line_q);
				end
				M_STAR: begin
					if (c == 8'h2f) m = M_IDLE;
					else if (c != 8'h2a) begin
						m = M_BLOCK;
						if (c == 8'h0a) line_n = sat(line_q);
					end
				end
				default: again = 1'b1;
			endcase
			// A byte that ended the previous token is scanned from idle.
			if (again) begin
				m = M_IDLE;
				case (c)
					8'h20, 8'h0d, 8'h09: ;
					8'h0a: line_n = sat(line_q);
					8'h28: k1 = 6'd0;
					8'h29: k1 = 6'd1;
					8'h7b: k1 = 6'd2;
					8'h7d: k1 = 6'd3;
					8'h3b: k1 = 6'd4;
					8'h2c: k1 = 6'd5;
					8'h2e: k1 = 6'd6;
					8'h5d: k1 = 6'd7;
					8'h5b: k1 = 6'd8;
					8'h3a: k1 = 6'd9;
					8'h2a: k1 = 6'd15;
					8'h25: k1 = 6'd16;
					8'h2b, 8'h2d, 8'h21, 8'h3d, 8'h3c, 8'h3e, 8'h2f: begin
						m = M_OP; origin_n = off_q; run_n = 16'd1; pend_n = c;
					end
					8'h22: begin m = M_STR; origin_n = off_q; run_n = 16'd1; end
					default: begin
						if (is_letter(c)) begin
							m = M_IDENT; origin_n = off_q; run_n = 16'd1; prefix_n = 64'(c);
						end else if (is_num(c)) begin
							m = M_INT; origin_n = off_q; run_n = 16'd1;
						end else k1 = K_ERR_CHAR;
					end
				endcase
				if (k1 != K_NONE) begin
					toks[n] = '{k1, 24'(off_q), 16'd1, line_n, 1'b0}; n = n + 3'd1;
				end
			end
			off_n = off_q + OFFSET_BITS'(1);
		end
		// Close of source.
		if (c == 8'h00 || end_of_source) begin
			unique case (m)
				M_IDENT: begin
					toks[n] = '{kw_kind(prefix_n, run_n), 24'(origin_n), run_n, line_n, 1'b0};
					n = n + 3'd1;
				end
				M_INT, M_FRAC: begin
					toks[n] = '{K_NUMBER, 24'(origin_n), run_n, line_n, 1'b0}; n = n + 3'd1;
				end
				M_DOT: begin
					toks[n] = '{K_NUMBER, 24'(origin_n), run_n, line_n, 1'b0}; n = n + 3'd1;
					toks[n] = '{K_DOT, 24'(off_n - OFFSET_BITS'(1)), 16'd1, line_n, 1'b0};
					n = n + 3'd1;
				end
				M_STR: begin
					toks[n] = '{K_ERR_STRING, 24'(origin_n), run_n, line_n, 1'b0};
					n = n + 3'd1;
				end
				M_OP: begin
					toks[n] = '{op1(pend_n), 24'(origin_n), 16'd1, line_n, 1'b0}; n = n + 3'd1;
				end
				default: ;
			endcase
			toks[n] = '{K_EOF, 24'(off_n), 16'd0, line_n, 1'b0}; n = n + 3'd1;
			m = M_IDLE; off_n = '0; origin_n = '0; line_n = 16'd1;
			prefix_n = '0; pend_n = 8'h00; run_n = 16'd0;
		end
		if (n != 3'd0) toks[n - 3'd1].last = 1'b1;
		tok_count = n;
	end

	// The identifier prefix feeding wk comes from the stored word, but an
	// identifier closed on this byte extends it first; use the updated
	// prefix when the close falls on the same byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; off_q <= '0; origin_q <= '0; line_q <= 16'd1;
			run_q <= 16'd0; prefix_q <= '0; pend_q <= 8'h00;
		end else if (step) begin
			mode_q <= m; off_q <= off_n; origin_q <= origin_n; line_q <= line_n;
			run_q <= run_n; prefix_q <= prefix_n; pend_q <= pend_n;
		end
	end
endmodule

// File: design/sts_back.sv
// Token queue and serializer: up to four tokens in, one out a cycle while out_ready.
module sts_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sts_pkg::token_t [3:0] toks,
	input  logic [2:0]            tok_count,
	output logic                  room,
	output logic                  out_valid,
	output sts_pkg::token_t       out_tok,
	input  logic                  out_ready
);
	import sts_pkg::*;

	localparam int DEPTH = 8;
	token_t     mem_q [DEPTH];
	logic [2:0] wr_q, rd_q;
	logic [3:0] cnt_q;
	logic       pop;

	assign out_valid = cnt_q != 4'd0;
	assign out_tok = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	assign room = cnt_q <= 4'd4;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < 4; i++)
				if (3'(i) < tok_count) mem_q[wr_q + 3'(i)] <= toks[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + tok_count;
			if (pop) rd_q <= rd_q + 3'd1;
			cnt_q <= cnt_q + (push ? {1'b0, tok_count} : 4'd0) - (pop ? 4'd1 : 4'd0);
		end
	end
endmodule

// File: design/script_token_scanner_core.sv
// Top level of the script token scanner.
// The scanner takes one source word per cycle whenever its token queue has room for
// the up to four tokens a byte can cause; the front end computes each scan step in
// combinational logic, and the eight-entry queue drains one token word per cycle
// while the sink is ready. A burst of tokens longer than the queue can absorb
// stalls input until the sink catches up. Byte zero or the end flag closes the
// source, emits pending token and EOF, and restarts offset and line counting.
module script_token_scanner_core #(
	parameter int OFFSET_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	sts_if.sink   in_ch,
	sts_if.source out_ch
);
	import sts_pkg::*;

	token_t [3:0] toks;
	logic [2:0]   tok_count;
	logic         room, step, ov;
	token_t       ot;

	assign in_ch.ready = room;
	assign step = in_ch.valid && room;

	// Front end: scan and classify one byte.
	sts_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk, .arst_n, .step,
		.source_byte(in_ch.data[7:0]), .end_of_source(in_ch.data[8]),
		.toks, .tok_count
	);

	// Back end: queue and serialize tokens.
	sts_back u_back (
		.clk, .arst_n, .push(step), .toks, .tok_count, .room,
		.out_valid(ov), .out_tok(ot), .out_ready(out_ch.ready)
	);

	assign out_ch.valid = ov;
	assign out_ch.data = ot;

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> tok_count <= 3'd4) else $error("too many tokens in one step");
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(step && in_ch.data[7:0] == 8'h00) |-> tok_count != 3'd0)
		else $error("close without EOF");
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ov |-> room) else $error("empty queue not ready");
endmodule

// File: tb/tb_script_token_scanner_core.sv
// Self-checking testbench for the script token scanner core.
module tb_script_token_scanner_core;
	import sts_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sts_if #(.W(9))          in_if (clk);
	sts_if #(.W(TOKEN_BITS)) out_if (clk);

	script_token_scanner_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if.sink),
		.out_ch (out_if.source)
	);

	// Free-running clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Keyword spellings in token-code order, starting at K_KW_BASE.
	string kw_names [32] = '{
		"and", "break", "case", "class", "continue", "default", "define", "do",
		"else", "endif", "false", "for", "if", "if_not", "ifdef", "ifndef",
		"impl", "include", "jump", "let", "label", "or", "pass", "print",
		"return", "switch", "true", "var", "void", "vector", "hashmap", "while"
	};

	// Scanner state mirrored by the predictor.
	scan_mode_t  sc_mode;
	logic [23:0] sc_offset;
	logic [23:0] sc_origin;
	logic [15:0] sc_line;
	logic [63:0] sc_prefix;
	logic [7:0]  sc_pend;
	logic [15:0] sc_len;

	token_t expected_tokens [$];
	logic [8:0] pending_words [$];
	int errors = 0;
	int words_in = 0;
	int tokens_out = 0;
	int closes = 0;

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void push_token(input logic [5:0] k, input logic [23:0] s,
			input logic [15:0] n);
		token_t t;
		t.kind = k;
		t.start = s;
		t.length = n;
		t.line = sc_line;
		t.last = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	function automatic void grow_len();
		if (sc_len != 16'hFFFF) sc_len++;
	endfunction

	function automatic void bump_line();
		if (sc_line != 16'hFFFF) sc_line++;
	endfunction

	// Exact match of the whole identifier against the keyword table.
	function automatic logic [5:0] word_kind();
		logic [63:0] packed_kw;
		for (int k = 0; k < 32; k++) begin
			packed_kw = '0;
			for (int n = 0; n < kw_names[k].len(); n++)
				packed_kw |= 64'(kw_names[k][n]) << (8 * n);
			if (sc_len <= 8 && sc_len == kw_names[k].len() && packed_kw == sc_prefix)
				return K_KW_BASE + 6'(k);
		end
		return K_IDENT;
	endfunction

	function automatic void start_token(input scan_mode_t m);
		sc_mode = m;
		sc_origin = sc_offset;
		sc_len = 1;
	endfunction

	// Single-character form of a held operator.
	function automatic void flush_operator();
		logic [5:0] k;
		case (sc_pend)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"!": k = K_BANG;
			"=": k = K_ASSIGN;
			"<": k = K_LESS;
			">": k = K_GREATER;
			default: k = K_SLASH;
		endcase
		push_token(k, sc_origin, 16'd1);
		sc_pend = 8'd0;
	endfunction

	function automatic void scan_between(input logic [7:0] c);
		case (c)
			" ", 8'h0D, 8'h09: ;
			8'h0A: bump_line();
			"(": push_token(6'd0, sc_offset, 16'd1);
			")": push_token(6'd1, sc_offset, 16'd1);
			"{": push_token(6'd2, sc_offset, 16'd1);
			"}": push_token(6'd3, sc_offset, 16'd1);
			";": push_token(6'd4, sc_offset, 16'd1);
			",": push_token(6'd5, sc_offset, 16'd1);
			".": push_token(K_DOT, sc_offset, 16'd1);
			"]": push_token(6'd7, sc_offset, 16'd1);
			"[": push_token(6'd8, sc_offset, 16'd1);
			":": push_token(6'd9, sc_offset, 16'd1);
			"*": push_token(6'd15, sc_offset, 16'd1);
			"%": push_token(6'd16, sc_offset, 16'd1);
			"+", "-", "!", "=", "<", ">", "/": begin
				start_token(M_OP);
				sc_pend = c;
			end
			"\"": start_token(M_STR);
			default: begin
				if (is_letter(c)) begin
					start_token(M_IDENT);
					sc_prefix = 64'(c);
				end else if (is_digit(c)) begin
					start_token(M_INT);
				end else begin
					push_token(K_ERR_CHAR, sc_offset, 16'd1);
				end
			end
		endcase
	endfunction

	// Returns 1 when the byte is consumed; 0 means rescan it from idle.
	function automatic bit scan_one(input logic [7:0] c);
		case (sc_mode)
			M_IDENT: begin
				if (is_letter(c) || is_digit(c)) begin
					if (sc_len < 8) sc_prefix |= 64'(c) << (8 * sc_len);
					grow_len();
					return 1'b1;
				end
				push_token(word_kind(), sc_origin, sc_len);
			end
			M_INT: begin
				if (is_digit(c)) begin
					grow_len();
					return 1'b1;
				end
				if (c == ".") begin
					sc_mode = M_DOT;
					return 1'b1;
				end
				push_token(K_NUMBER, sc_origin, sc_len);
			end
			M_DOT: begin
				if (is_digit(c)) begin
					grow_len();
					grow_len();
					sc_mode = M_FRAC;
					return 1'b1;
				end
				push_token(K_NUMBER, sc_origin, sc_len);
				push_token(K_DOT, sc_offset - 24'd1, 16'd1);
			end
			M_FRAC: begin
				if (is_digit(c)) begin
					grow_len();
					return 1'b1;
				end
				push_token(K_NUMBER, sc_origin, sc_len);
			end
			M_STR: begin
				grow_len();
				if (c == "\"") begin
					push_token(K_STRING, sc_origin, sc_len);
					sc_mode = M_IDLE;
				end else if (c == 8'h0A) begin
					bump_line();
				end
				return 1'b1;
			end
			M_OP: begin
				if (sc_pend == "/" && c == "/") begin
					sc_mode = M_LINECMT;
					sc_pend = 8'd0;
					return 1'b1;
				end else if (sc_pend == "/" && c == "*") begin
					sc_mode = M_BLOCK;
					sc_pend = 8'd0;
					return 1'b1;
				end else if (sc_pend != "/" && (sc_pend == "+" || sc_pend == "-")) begin
					if (c == sc_pend) begin
						push_token(sc_pend == "+" ? K_PLUSPLUS : K_MINUSMINUS,
							sc_origin, 16'd2);
						sc_pend = 8'd0;
						sc_mode = M_IDLE;
						return 1'b1;
					end
				end else if (sc_pend != "/" && c == "=") begin
					push_token(sc_pend == "!" ? K_BANG_EQ : sc_pend == "=" ? K_EQ_EQ :
						sc_pend == "<" ? K_LESS_EQ : K_GREATER_EQ, sc_origin, 16'd2);
					sc_pend = 8'd0;
					sc_mode = M_IDLE;
					return 1'b1;
				end
				flush_operator();
			end
			M_LINECMT: begin
				if (c != 8'h0A) return 1'b1;
			end
			M_BLOCK: begin
				if (c == "*") sc_mode = M_STAR;
				else if (c == 8'h0A) bump_line();
				return 1'b1;
			end
			M_STAR: begin
				if (c == "/") begin
					sc_mode = M_IDLE;
				end else if (c != "*") begin
					sc_mode = M_BLOCK;
					if (c == 8'h0A) bump_line();
				end
				return 1'b1;
			end
			default: begin
				sc_mode = M_IDLE;
				scan_between(c);
				return 1'b1;
			end
		endcase
		sc_mode = M_IDLE;
		return 1'b0;
	endfunction

	function automatic void reset_scan();
		sc_mode = M_IDLE;
		sc_offset = '0;
		sc_origin = '0;
		sc_line = 16'd1;
		sc_prefix = '0;
		sc_pend = '0;
		sc_len = '0;
	endfunction

	function automatic void close_scan();
		case (sc_mode)
			M_IDENT: push_token(word_kind(), sc_origin, sc_len);
			M_INT, M_FRAC: push_token(K_NUMBER, sc_origin, sc_len);
			M_DOT: begin
				push_token(K_NUMBER, sc_origin, sc_len);
				push_token(K_DOT, sc_offset - 24'd1, 16'd1);
			end
			M_STR: push_token(K_ERR_STRING, sc_origin, sc_len);
			M_OP: flush_operator();
			default: ;
		endcase
		push_token(K_EOF, sc_offset, 16'd0);
		closes++;
		reset_scan();
	endfunction

	// Predicts every token one accepted word causes; the last one is flagged.
	function automatic void predict_word(input logic [8:0] w);
		int before_count;
		before_count = expected_tokens.size();
		if (w[7:0] == 8'd0) begin
			close_scan();
		end else begin
			if (!scan_one(w[7:0])) void'(scan_one(w[7:0]));
			sc_offset++;
			if (w[8]) close_scan();
		end
		if (expected_tokens.size() > before_count)
			expected_tokens[$].last = 1'b1;
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) pending_words.push_back({1'b0, s[i]});
	endfunction

	function automatic logic [7:0] rand_letter();
		case ($urandom_range(2))
			0: return 8'($urandom_range("z", "a"));
			1: return 8'($urandom_range("Z", "A"));
			default: return "_";
		endcase
	endfunction

	// One random script fragment; most are well formed, some are noise.
	function automatic void add_fragment();
		string ops [17] = '{"+", "-", "!", "=", "<", ">", "/", "++", "--", "!=", "==",
			"<=", ">=", "(", ")", "{", "}"};
		string punct = ";,.][:*%";
		int n;
		case ($urandom_range(13))
			0, 1: add_text(kw_names[$urandom_range(31)]);
			2: begin
				n = $urandom_range(10, 1);
				for (int i = 0; i < n; i++)
					pending_words.push_back({1'b0, (i > 0 && $urandom_range(2) == 0) ?
						8'($urandom_range("9", "0")) : rand_letter()});
			end
			3: begin
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++)
					pending_words.push_back({1'b0, 8'($urandom_range("9", "0"))});
				if ($urandom_range(1)) begin
					add_text(".");
					if ($urandom_range(1)) add_text("25");
				end
			end
			4: begin
				add_text("\"");
				n = $urandom_range(6);
				for (int i = 0; i < n; i++)
					pending_words.push_back({1'b0, $urandom_range(3) == 0 ? 8'h0A :
						8'($urandom_range(126, 32) == 34 ? 65 : $urandom_range(126, 35))});
				if ($urandom_range(5) != 0) add_text("\"");
			end
			5, 6: add_text(ops[$urandom_range(16)]);
			7: pending_words.push_back({1'b0, punct[$urandom_range(7)]});
			8: add_text($urandom_range(1) ? "// note\n" : "/* a\n** b */");
			9: add_text($urandom_range(1) ? " " : ($urandom_range(1) ? "\n" : "\t\r"));
			10: pending_words.push_back({1'b0, 8'($urandom_range(255, 1))});
			11: if ($urandom_range(3) == 0) pending_words.push_back(9'($urandom_range(1) ?
					9'h000 : 9'h100));
			12: if ($urandom_range(5) == 0) pending_words.push_back(9'h100 |
					9'($urandom_range(255)));
			default: add_text(" ");
		endcase
		add_text($urandom_range(1) ? " " : "");
	endfunction

	// Sender: bursts of random length separated by random gaps.
	logic in_fire;
	int burst_left = 0;
	int gap_left = 0;
	bit stim_done = 1'b0;

	always @(posedge clk) begin
		in_fire = in_if.valid && in_if.ready;
		if (in_fire) begin
			predict_word(in_if.data);
			words_in++;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (!in_if.valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_if.valid <= 1'b0;
			end else if (pending_words.size() == 0) begin
				in_if.valid <= 1'b0;
			end else begin
				in_if.valid <= 1'b1;
				in_if.data <= pending_words.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(40, 1);
					gap_left = $urandom_range(3) == 0 ? $urandom_range(6, 1) : 0;
				end
			end
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off mid-run.
	int hold_left = 0;
	bit held_once = 1'b0;
	int ready_phase = 0;

	always @(negedge clk) begin
		ready_phase++;
		if (!held_once && words_in > 150) begin
			held_once = 1'b1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else if ((ready_phase / 64) % 3 == 0) begin
			out_if.ready <= 1'b1;
		end else begin
			out_if.ready <= $urandom_range(3) != 0;
		end
	end

	// Checks every token word against the oldest prediction.
	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (out_if.valid && out_if.ready) begin
			got = out_if.data;
			tokens_out++;
			if (expected_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token, actual %p", $time, got);
			end else begin
				want = expected_tokens.pop_front();
				if (got.kind !== want.kind || got.start !== want.start ||
						got.length !== want.length || got.line !== want.line ||
						got.last !== want.last) begin
					errors++;
					$display("%0t: token mismatch, expected %p, actual %p",
						$time, want, got);
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			idle_cycles = 0;
		end else if (arst_n && !stim_done) begin
			idle_cycles++;
			if (idle_cycles >= 5000) begin
				$display("%0t: watchdog expired", $time);
				$display("tb_script_token_scanner_core: FAIL");
				$finish;
			end
		end
	end

	initial begin
		in_if.valid = 1'b0;
		in_if.data = '0;
		out_if.ready = 1'b0;
		reset_scan();
		// Directed: lone i, if, number-dot pair, open string closed by the end flag.
		add_text("i if 7.x ");
		add_text("a<=\v");
		pending_words.push_back(9'h1FF);
		add_text("/*/ */\"ab");
		pending_words.push_back(9'h000);
		add_text("\"q");
		pending_words.push_back(9'h100 | 9'h0A);
		pending_words.push_back(9'h100 | 9'h2E);
		while (pending_words.size() < 410) add_fragment();
		pending_words.push_back(9'h000);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_words.size() == 0 && !in_if.valid);
		wait (expected_tokens.size() == 0);
		stim_done = 1'b1;
		repeat (50) @(posedge clk);
		$display("Scanned %0d source words over %0d closes; checked %0d tokens.",
			words_in, closes, tokens_out);
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("tb_script_token_scanner_core: PASS");
		end else begin
			$display("%0d errors, %0d tokens still expected", errors,
				expected_tokens.size());
			$display("tb_script_token_scanner_core: FAIL");
		end
		$finish;
	end

endmodule
